[hdl/stdp_pkg.sv]
// stdp_pkg: shared types, register codes and the exponential window table
// for the spike-timing weight update core. No dependencies.
`default_nettype none

package stdp_pkg;

	// configuration port geometry and register codes
	localparam int CFG_INDEX_BITS = 1;
	localparam int CFG_DATA_BITS  = 24;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_MAX_CHANGE = 1'b0,
		REG_DECAY_RATE = 1'b1
	} cfg_reg_t;

	// fixed field widths of the configuration registers
	localparam int CHANGE_BITS = 16;
	localparam int DECAY_BITS  = 24;

	localparam logic [CHANGE_BITS-1:0] MAX_CHANGE_RESET = 16'd41;
	localparam logic [DECAY_BITS-1:0]  DECAY_RATE_RESET = 24'd839;

	// window arithmetic
	localparam int EXP_BITS    = 17;  // exp(-i/32) in Q1.16, entry 0 is 1.0
	localparam int TERM_BITS   = 16;  // Q4.12 change term
	localparam int MAG_BITS    = 40;  // largest age difference that can land in the table
	localparam int MAG_SPLIT   = 20;  // the age difference is multiplied in two halves
	localparam int PART_BITS   = MAG_SPLIT + DECAY_BITS;
	localparam int PROD_BITS   = MAG_BITS + DECAY_BITS;
	localparam int INDEX_SHIFT = 19;  // Q.24 product to 1/32 steps
	localparam int IDX_FULL_BITS = PROD_BITS - INDEX_SHIFT;

	localparam logic [63:0] EXP_STEP_Q30 = 64'd1040706260;

	// configuration registers as seen by the datapath
	typedef struct packed {
		logic [CHANGE_BITS-1:0] max_change;
		logic [DECAY_BITS-1:0]  decay_rate;
	} cfg_t;

	// control bits that travel with each word
	typedef struct packed {
		logic valid;
		logic grow;
	} ctl_t;

	// table entry n: n decay steps in Q32.32 with round-half-up, then rounded to Q1.16
	function automatic logic [EXP_BITS-1:0] exp_entry(input int unsigned n);
		logic [63:0] e;
		logic [63:0] r;
		e = 64'd1 << 32;
		for (int unsigned k = 0; k < n; k++) begin
			e = (e * EXP_STEP_Q30 + (64'd1 << 29)) >> 30;
		end
		r = (e + 64'd32768) >> 16;
		return r[EXP_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

[hdl/stdp_cfg.sv]
// stdp_cfg: configuration registers (max change, decay rate) behind a plain write port.
// Depends on stdp_pkg.
`default_nettype none

module stdp_cfg (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [stdp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [stdp_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
	output stdp_pkg::cfg_t                           cfg
);

	stdp_pkg::cfg_t cfg_q;

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_change <= stdp_pkg::MAX_CHANGE_RESET;
			cfg_q.decay_rate <= stdp_pkg::DECAY_RATE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				stdp_pkg::REG_MAX_CHANGE: begin
					cfg_q.max_change <= cfg_wdata[stdp_pkg::CHANGE_BITS-1:0];
				end
				stdp_pkg::REG_DECAY_RATE: begin
					cfg_q.decay_rate <= cfg_wdata[stdp_pkg::DECAY_BITS-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[hdl/stdp_age.sv]
// stdp_age: stages 1-2, spike ages and the signed age difference split into
// direction and magnitude. Depends on stdp_pkg.
`default_nettype none

module stdp_age #(
	parameter int TIME_BITS = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic [TIME_BITS-1:0] current_time,
	input  wire logic [TIME_BITS-1:0] pre_spike_time,
	input  wire logic [TIME_BITS-1:0] post_spike_time,
	output stdp_pkg::ctl_t            ctl_s2,
	output logic [TIME_BITS-1:0]      mag_s2
);

	logic                 valid_s1;
	logic [TIME_BITS-1:0] pre_age_s1;
	logic [TIME_BITS-1:0] post_age_s1;
	logic                 grow;

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	// stage 1 ages, wrapping modulo the time width
	always_ff @(posedge clk) begin
		pre_age_s1  <= current_time - pre_spike_time;
		post_age_s1 <= current_time - post_spike_time;
	end

	// younger presynaptic spike means the pair potentiates
	assign grow = pre_age_s1 < post_age_s1;

	// stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2.valid <= valid_s1;
			ctl_s2.grow  <= grow;
		end
	end

	// stage 2 magnitude of the age difference
	always_ff @(posedge clk) begin
		mag_s2 <= grow ? (post_age_s1 - pre_age_s1) : (pre_age_s1 - post_age_s1);
	end

endmodule

`default_nettype wire

[hdl/stdp_expw.sv]
// stdp_expw: stages 3-6, decay product, table index, exponential lookup and
// scaling by the peak change. Depends on stdp_pkg (table function, types).
`default_nettype none

module stdp_expw #(
	parameter int TIME_BITS       = 32,
	parameter int EXP_TABLE_DEPTH = 256
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire stdp_pkg::ctl_t                     ctl_in,
	input  wire logic [TIME_BITS-1:0]               mag,
	input  wire stdp_pkg::cfg_t                     cfg,
	output stdp_pkg::ctl_t                          ctl_s6,
	output logic [stdp_pkg::TERM_BITS-1:0]          term_s6
);

	localparam int IDX_BITS = $clog2(EXP_TABLE_DEPTH);

	logic [stdp_pkg::EXP_BITS-1:0]      exp_rom [EXP_TABLE_DEPTH];

	logic [TIME_BITS+stdp_pkg::MAG_BITS-1:0] mag_ext;
	logic [stdp_pkg::MAG_BITS-1:0]      mag40;
	logic                               far;

	stdp_pkg::ctl_t                     ctl_s3;
	stdp_pkg::ctl_t                     ctl_s4;
	stdp_pkg::ctl_t                     ctl_s5;
	logic                               far_s3;
	logic                               zero_rate_s3;
	logic [stdp_pkg::PART_BITS-1:0]     p_lo_s3;
	logic [stdp_pkg::PART_BITS-1:0]     p_hi_s3;

	logic [stdp_pkg::PROD_BITS-1:0]     prod_full;
	logic [stdp_pkg::IDX_FULL_BITS-1:0] idx_full;
	logic                               in_range;
	logic                               in_range_s4;
	logic [IDX_BITS-1:0]                idx_s4;

	logic [stdp_pkg::EXP_BITS-1:0]      entry_s5;

	logic [stdp_pkg::CHANGE_BITS+stdp_pkg::EXP_BITS-1:0]   scaled;
	logic [stdp_pkg::CHANGE_BITS+stdp_pkg::EXP_BITS:0]     rounded;

	// constant window table
	for (genvar i = 0; i < EXP_TABLE_DEPTH; i++) begin : g_rom
		assign exp_rom[i] = stdp_pkg::exp_entry(i);
	end

	// differences of 2^40 ticks or more are past the table for any nonzero rate
	assign mag_ext = {{stdp_pkg::MAG_BITS{1'b0}}, mag};
	assign mag40   = mag_ext[stdp_pkg::MAG_BITS-1:0];
	assign far     = (mag_ext >> stdp_pkg::MAG_BITS) != '0;

	// stage 3 partial products of the decay argument
	always_ff @(posedge clk) begin
		far_s3       <= far;
		zero_rate_s3 <= cfg.decay_rate == '0;
		p_lo_s3 <= stdp_pkg::PART_BITS'(mag40[stdp_pkg::MAG_SPLIT-1:0])
			* stdp_pkg::PART_BITS'(cfg.decay_rate);
		p_hi_s3 <= stdp_pkg::PART_BITS'(mag40[stdp_pkg::MAG_BITS-1:stdp_pkg::MAG_SPLIT])
			* stdp_pkg::PART_BITS'(cfg.decay_rate);
	end

	// stage 4 combine halves and derive table index
	assign prod_full = stdp_pkg::PROD_BITS'(p_lo_s3)
		+ {p_hi_s3, {stdp_pkg::MAG_SPLIT{1'b0}}};
	assign idx_full  = prod_full[stdp_pkg::PROD_BITS-1:stdp_pkg::INDEX_SHIFT];
	assign in_range  = zero_rate_s3
		|| (!far_s3 && (idx_full < stdp_pkg::IDX_FULL_BITS'(EXP_TABLE_DEPTH)));

	always_ff @(posedge clk) begin
		in_range_s4 <= in_range;
		idx_s4      <= zero_rate_s3 ? '0 : idx_full[IDX_BITS-1:0];
	end

	// stage 5 table read, zero past the window
	always_ff @(posedge clk) begin
		entry_s5 <= in_range_s4 ? exp_rom[idx_s4] : '0;
	end

	// stage 6 scale by peak change with round-half-up to Q4.12
	assign scaled  = (stdp_pkg::CHANGE_BITS + stdp_pkg::EXP_BITS)'(cfg.max_change)
		* (stdp_pkg::CHANGE_BITS + stdp_pkg::EXP_BITS)'(entry_s5);
	assign rounded = (stdp_pkg::CHANGE_BITS + stdp_pkg::EXP_BITS + 1)'(scaled)
		+ (stdp_pkg::CHANGE_BITS + stdp_pkg::EXP_BITS + 1)'(32768);

	always_ff @(posedge clk) begin
		term_s6 <= rounded[stdp_pkg::TERM_BITS+15:16];
	end

	// control travels alongside
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
		end else begin
			ctl_s3 <= ctl_in;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
		end
	end

endmodule

`default_nettype wire

[hdl/stdp_clamp.sv]
// stdp_clamp: stage 7, applies the change term and clamps to [0, bound].
// Depends on stdp_pkg.
`default_nettype none

module stdp_clamp #(
	parameter int WEIGHT_BITS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire stdp_pkg::ctl_t                    ctl,
	input  wire logic [stdp_pkg::TERM_BITS-1:0]    term,
	input  wire logic [WEIGHT_BITS-1:0]            old_weight,
	input  wire logic [WEIGHT_BITS-1:0]            weight_bound,
	output logic                                   done_s7,
	output logic [WEIGHT_BITS-1:0]                 new_weight_s7,
	output logic                                   hit_upper_s7,
	output logic                                   hit_lower_s7
);

	localparam int SUM_BITS =
		((WEIGHT_BITS > stdp_pkg::TERM_BITS) ? WEIGHT_BITS : stdp_pkg::TERM_BITS) + 2;

	logic [SUM_BITS-1:0]    old_ext;
	logic [SUM_BITS-1:0]    term_ext;
	logic [SUM_BITS-1:0]    bound_ext;
	logic [SUM_BITS-1:0]    sum;
	logic                   neg;
	logic                   up;

	// signed sum, top bit marks a negative result
	assign old_ext   = SUM_BITS'(old_weight);
	assign term_ext  = SUM_BITS'(term);
	assign bound_ext = SUM_BITS'(weight_bound);
	assign sum       = ctl.grow ? (old_ext + term_ext) : (old_ext - term_ext);
	assign neg       = sum[SUM_BITS-1];
	assign up        = !neg && (sum > bound_ext);

	// strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s7 <= 1'b0;
		end else begin
			done_s7 <= ctl.valid;
		end
	end

	// clamp, upper bound tested first
	always_ff @(posedge clk) begin
		hit_upper_s7 <= up;
		hit_lower_s7 <= !up && neg;
		if (up) begin
			new_weight_s7 <= weight_bound;
		end else if (neg) begin
			new_weight_s7 <= '0;
		end else begin
			new_weight_s7 <= sum[WEIGHT_BITS-1:0];
		end
	end

endmodule

`default_nettype wire

[hdl/stdp_weight_update_core.sv]
// stdp_weight_update_core: top level of the pair-based STDP weight update.
// Depends on stdp_pkg, stdp_cfg, stdp_age, stdp_expw, stdp_clamp.
//
//   channel   | ports                                                    | handshake
//   ----------+----------------------------------------------------------+------------------
//   input     | current_time, pre/post_spike_time, old_weight, w. bound  | start && !busy
//   result    | new_weight, hit_upper, hit_lower                         | done, one cycle
//   config    | cfg_index, cfg_wdata                                     | cfg_we
//
// One word is taken every cycle; each result leaves the clamp stage after stages 1 to 6.
// The path runs through the decay product, split into two 20x24 partial products,
// followed by the index stage, the window table read and the change scaling.
// busy stays low: nothing stalls, the receiver takes every result as it comes.
// Reset clears the pipeline valid bits and loads the register defaults.
`default_nettype none

module stdp_weight_update_core #(
	parameter int EXP_TABLE_DEPTH = 256,
	parameter int TIME_BITS       = 32,
	parameter int WEIGHT_BITS     = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic [TIME_BITS-1:0]                current_time,
	input  wire logic [TIME_BITS-1:0]                pre_spike_time,
	input  wire logic [TIME_BITS-1:0]                post_spike_time,
	input  wire logic [WEIGHT_BITS-1:0]              old_weight,
	input  wire logic [WEIGHT_BITS-1:0]              weight_bound,
	output logic                                     done,
	output logic [WEIGHT_BITS-1:0]                   new_weight,
	output logic                                     hit_upper,
	output logic                                     hit_lower,
	input  wire logic                                cfg_we,
	input  wire logic [stdp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [stdp_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

	stdp_pkg::cfg_t                 cfg;
	stdp_pkg::ctl_t                 ctl_s2;
	stdp_pkg::ctl_t                 ctl_s6;
	logic [TIME_BITS-1:0]           mag_s2;
	logic [stdp_pkg::TERM_BITS-1:0] term_s6;
	logic                           accept;

	logic [WEIGHT_BITS-1:0] old_weight_s1, old_weight_s2, old_weight_s3;
	logic [WEIGHT_BITS-1:0] old_weight_s4, old_weight_s5, old_weight_s6;
	logic [WEIGHT_BITS-1:0] bound_s1, bound_s2, bound_s3;
	logic [WEIGHT_BITS-1:0] bound_s4, bound_s5, bound_s6;

	// the pipeline never stalls
	assign busy   = 1'b0;
	assign accept = start && !busy;

	stdp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	stdp_age #(
		.TIME_BITS (TIME_BITS)
	) u_age (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (accept),
		.current_time    (current_time),
		.pre_spike_time  (pre_spike_time),
		.post_spike_time (post_spike_time),
		.ctl_s2          (ctl_s2),
		.mag_s2          (mag_s2)
	);

	stdp_expw #(
		.TIME_BITS       (TIME_BITS),
		.EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
	) u_expw (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_in  (ctl_s2),
		.mag     (mag_s2),
		.cfg     (cfg),
		.ctl_s6  (ctl_s6),
		.term_s6 (term_s6)
	);

	// weight and bound ride along until the clamp stage
	always_ff @(posedge clk) begin
		old_weight_s1 <= old_weight;
		old_weight_s2 <= old_weight_s1;
		old_weight_s3 <= old_weight_s2;
		old_weight_s4 <= old_weight_s3;
		old_weight_s5 <= old_weight_s4;
		old_weight_s6 <= old_weight_s5;
		bound_s1      <= weight_bound;
		bound_s2      <= bound_s1;
		bound_s3      <= bound_s2;
		bound_s4      <= bound_s3;
		bound_s5      <= bound_s4;
		bound_s6      <= bound_s5;
	end

	stdp_clamp #(
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_clamp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl_s6),
		.term          (term_s6),
		.old_weight    (old_weight_s6),
		.weight_bound  (bound_s6),
		.done_s7       (done),
		.new_weight_s7 (new_weight),
		.hit_upper_s7  (hit_upper),
		.hit_lower_s7  (hit_lower)
	);

	// every accepted word gives exactly one result strobe, and no strobe comes without one
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done == $past(accept && arst_n, 7))
		else $error("result strobe does not match accepted word");

	// only one clamp can act on a word
	a_one_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(hit_upper && hit_lower))
		else $error("both clamps flagged");

	// lower clamp forces a zero weight
	a_lower_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && hit_lower) |-> (new_weight == '0))
		else $error("lower clamp with nonzero weight");

endmodule

`default_nettype wire
